/* hw/rtl/rsac_pkg.sv */
// Package for the rotated sprite compositor: shared types, register codes,
// reset values and fixed field widths. No dependencies.
package rsac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ANG_W      = 16;
    localparam int COORD_W    = 9;
    localparam int FX_W       = COORD_W + 1;
    localparam int PROD_W     = FX_W + ANG_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int TADDR_W    = 14;
    localparam int TEXEL_W    = 16;
    localparam int ARGB_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_ANGLE     = 3'd0,
        REG_SIN_ANGLE     = 3'd1,
        REG_CENTER_X      = 3'd2,
        REG_CENTER_Y      = 3'd3,
        REG_PIVOT_X       = 3'd4,
        REG_PIVOT_Y       = 3'd5,
        REG_SPRITE_WIDTH  = 3'd6,
        REG_SPRITE_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD      = 1'b0,
        OP_COMPOSITE = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [ANG_W-1:0]   cos_angle;
        logic signed [ANG_W-1:0]   sin_angle;
        logic        [COORD_W-1:0] center_x;
        logic        [COORD_W-1:0] center_y;
        logic        [5:0]         pivot_x;
        logic        [7:0]         pivot_y;
        logic        [6:0]         sprite_width;
        logic        [8:0]         sprite_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cos_angle:     16'sd16384,
        sin_angle:     16'sd0,
        center_x:      9'd240,
        center_y:      9'd240,
        pivot_x:       6'd32,
        pivot_y:       8'd50,
        sprite_width:  7'd63,
        sprite_height: 9'd240
    };

    typedef struct packed {
        op_t                 operation;
        logic [TADDR_W-1:0]  texel_address;
        logic [TEXEL_W-1:0]  texel_value;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [ARGB_W-1:0]   background_argb;
    } in_word_t;

    // carried alongside the mapping stages
    typedef struct packed {
        op_t                 operation;
        logic [TADDR_W-1:0]  texel_address;
        logic [TEXEL_W-1:0]  texel_value;
        logic [ARGB_W-1:0]   background_argb;
    } carry_t;

    // mapping stage to store access stage
    typedef struct packed {
        logic                valid;
        op_t                 operation;
        logic                in_bounds;
        logic                wr_en;
        logic [TEXEL_W-1:0]  texel_value;
        logic [ARGB_W-1:0]   background_argb;
    } map_req_t;

    // store access stage to blend
    typedef struct packed {
        logic                valid;
        logic                in_bounds;
        logic [ARGB_W-1:0]   background_argb;
    } blend_req_t;

    typedef struct packed {
        logic                valid;
        logic [ARGB_W-1:0]   pixel_argb;
        logic                sprite_hit;
    } result_t;

endpackage

/* hw/rtl/rsac_in_if.sv */
// Input channel of the rotated sprite compositor: valid/ready plus one word.
// No dependencies.
interface rsac_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [13:0] texel_address;
    logic [15:0] texel_value;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [31:0] background_argb;

    modport source (
        output valid, operation, texel_address, texel_value, pixel_x, pixel_y,
               background_argb,
        input  ready
    );
    modport sink (
        input  valid, operation, texel_address, texel_value, pixel_x, pixel_y,
               background_argb,
        output ready
    );
endinterface

/* hw/rtl/rsac_out_if.sv */
// Output channel of the rotated sprite compositor: valid/ready plus one word.
// No dependencies.
interface rsac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;
    logic        sprite_hit;

    modport source (
        output valid, pixel_argb, sprite_hit,
        input  ready
    );
    modport sink (
        input  valid, pixel_argb, sprite_hit,
        output ready
    );
endinterface

/* hw/rtl/rotated_sprite_alpha_compositor.sv */
// Rotated sprite compositor with alpha blend, top level: config registers,
// sprite store, pipeline control. Depends on rsac_pkg, rsac_in_if,
// rsac_out_if, rsac_map, rsac_ram, rsac_blend.
//
// Takes one word per clock while the pipeline is not held, load or composite,
// and returns one result per composite word through five mapping stages, the
// registered sprite store read, one blend stage and the output register. The
// whole pipeline advances together: it holds while a result sits unaccepted
// in the output register, and empty slots travel along with it when it moves.
// Loads write the store in the same stage where composites read it, so every
// composite sees exactly the loads accepted before it. The store is not
// cleared at reset; texels must be loaded before they are used.
module rotated_sprite_alpha_compositor
    import rsac_pkg::*;
#(
    parameter int SPRITE_MAX_W = 64,
    parameter int SPRITE_MAX_H = 256,
    parameter int FRAC_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rsac_in_if.sink               pixel_in,
    rsac_out_if.source            pixel_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = SPRITE_MAX_W * SPRITE_MAX_H;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_t              cfg_reg, cfg_next;
    logic              en;
    in_word_t          in_word;
    map_req_t          map_req;
    logic [ADDR_W-1:0] map_addr;
    blend_req_t        ram_stage_reg;
    logic [TEXEL_W-1:0] texel;
    result_t           blend_res;
    logic              out_valid_reg;
    logic [ARGB_W-1:0] out_argb_reg;
    logic              out_hit_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COS_ANGLE:     cfg_next.cos_angle     = $signed(cfg_data);
                REG_SIN_ANGLE:     cfg_next.sin_angle     = $signed(cfg_data);
                REG_CENTER_X:      cfg_next.center_x      = cfg_data[8:0];
                REG_CENTER_Y:      cfg_next.center_y      = cfg_data[8:0];
                REG_PIVOT_X:       cfg_next.pivot_x       = cfg_data[5:0];
                REG_PIVOT_Y:       cfg_next.pivot_y       = cfg_data[7:0];
                REG_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_data[6:0];
                REG_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_data[8:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign en = !out_valid_reg || pixel_out.ready;
    assign pixel_in.ready = en;

    assign in_word = '{
        operation:       op_t'(pixel_in.operation),
        texel_address:   pixel_in.texel_address,
        texel_value:     pixel_in.texel_value,
        pixel_x:         pixel_in.pixel_x,
        pixel_y:         pixel_in.pixel_y,
        background_argb: pixel_in.background_argb
    };

    rsac_map #(
        .SPRITE_MAX_W (SPRITE_MAX_W),
        .SPRITE_MAX_H (SPRITE_MAX_H),
        .FRAC_BITS    (FRAC_BITS),
        .ADDR_W       (ADDR_W)
    ) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pixel_in.valid),
        .in_word  (in_word),
        .cfg      (cfg_reg),
        .req      (map_req),
        .addr     (map_addr)
    );

    rsac_ram #(
        .WIDTH  (TEXEL_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (en && map_req.valid && map_req.wr_en),
        .wr_addr (map_addr),
        .wr_data (map_req.texel_value),
        .rd_en   (en),
        .rd_addr (map_addr),
        .rd_data (texel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_stage_reg <= '0;
        end
        else if (en)
        begin
            ram_stage_reg <= '{
                valid:           map_req.valid && (map_req.operation == OP_COMPOSITE),
                in_bounds:       map_req.in_bounds,
                background_argb: map_req.background_argb
            };
        end
    end

    rsac_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (ram_stage_reg),
        .texel (texel),
        .res   (blend_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= blend_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_argb_reg <= blend_res.pixel_argb;
            out_hit_reg  <= blend_res.sprite_hit;
        end
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.pixel_argb = out_argb_reg;
    assign pixel_out.sprite_hit = out_hit_reg;

endmodule

/* hw/rtl/rsac_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module rsac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/rsac_map.sv */
// Inverse rotation pipeline: offsets, products, sums, rounding, bounds and
// store address over five register stages. Depends on rsac_pkg.
module rsac_map
    import rsac_pkg::*;
#(
    parameter int SPRITE_MAX_W = 64,
    parameter int SPRITE_MAX_H = 256,
    parameter int FRAC_BITS = 14,
    parameter int ADDR_W = $clog2(SPRITE_MAX_W * SPRITE_MAX_H)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  in_word_t          in_word,
    input  cfg_t              cfg,
    output map_req_t          req,
    output logic [ADDR_W-1:0] addr
);

    localparam int NUM_STG = 5;
    localparam int Q_W     = ACC_W - FRAC_BITS;
    localparam int S_W     = Q_W + 1;
    localparam int COL_W   = $clog2(SPRITE_MAX_W);
    localparam int ROW_W   = $clog2(SPRITE_MAX_H);
    localparam int DEPTH   = SPRITE_MAX_W * SPRITE_MAX_H;
    localparam int CMP_W   = (ADDR_W + 1 > TADDR_W) ? ADDR_W + 1 : TADDR_W;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);

    logic [NUM_STG-1:0] valid_reg;
    carry_t             carry_reg [NUM_STG];

    logic signed [FX_W-1:0]   fx_reg, fy_reg, fx_next, fy_next;
    logic signed [PROD_W-1:0] p_uc_reg, p_us_reg, p_vc_reg, p_vs_reg;
    logic signed [ACC_W-1:0]  t_u_reg, t_v_reg, t_u_next, t_v_next;
    logic signed [S_W-1:0]    sx_reg, sy_reg, sx_next, sy_next;
    logic                     inside_reg, inside_next;
    logic                     wr_en_reg, wr_en_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;

    logic signed [ACC_W-1:0]  r_u, r_v;
    logic signed [S_W-1:0]    q_u, q_v, piv_x, piv_y, w_ext, h_ext, w_lim, h_lim;
    logic [CMP_W-1:0]         load_addr;
    logic [ADDR_W-1:0]        tex_index;
    carry_t                   carry_next;

    always_comb
    begin
        carry_next = '{
            operation:       in_word.operation,
            texel_address:   in_word.texel_address,
            texel_value:     in_word.texel_value,
            background_argb: in_word.background_argb
        };
        fx_next = $signed({1'b0, in_word.pixel_x}) - $signed({1'b0, cfg.center_x});
        fy_next = $signed({1'b0, in_word.pixel_y}) - $signed({1'b0, cfg.center_y});

        t_u_next = ACC_W'(p_uc_reg) + ACC_W'(p_us_reg) + HALF;
        t_v_next = ACC_W'(p_vc_reg) - ACC_W'(p_vs_reg) + HALF;

        // divide by 2^FRAC_BITS toward zero
        r_u = t_u_reg + (t_u_reg[ACC_W-1] ? TRUNC_BIAS : '0);
        r_v = t_v_reg + (t_v_reg[ACC_W-1] ? TRUNC_BIAS : '0);
        q_u = S_W'($signed(r_u[ACC_W-1:FRAC_BITS]));
        q_v = S_W'($signed(r_v[ACC_W-1:FRAC_BITS]));
        piv_x = S_W'(cfg.pivot_x);
        piv_y = S_W'(cfg.pivot_y);
        sx_next = piv_x + q_u;
        sy_next = piv_y + q_v;

        w_ext = S_W'(cfg.sprite_width);
        h_ext = S_W'(cfg.sprite_height);
        w_lim = (w_ext > S_W'(SPRITE_MAX_W)) ? S_W'(SPRITE_MAX_W) : w_ext;
        h_lim = (h_ext > S_W'(SPRITE_MAX_H)) ? S_W'(SPRITE_MAX_H) : h_ext;
        inside_next = !sx_reg[S_W-1] && (sx_reg < w_lim)
                   && !sy_reg[S_W-1] && (sy_reg < h_lim);

        tex_index = ADDR_W'(sy_reg[ROW_W-1:0]) * ADDR_W'(SPRITE_MAX_W)
                  + ADDR_W'(sx_reg[COL_W-1:0]);
        load_addr = CMP_W'(carry_reg[3].texel_address);
        if (carry_reg[3].operation == OP_LOAD)
        begin
            addr_next  = load_addr[ADDR_W-1:0];
            wr_en_next = (load_addr < CMP_W'(DEPTH));
        end
        else
        begin
            addr_next  = tex_index;
            wr_en_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NUM_STG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg[0] <= carry_next;
            for (int i = 1; i < NUM_STG; i++)
            begin
                carry_reg[i] <= carry_reg[i-1];
            end
            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            p_uc_reg   <= fx_reg * cfg.cos_angle;
            p_us_reg   <= fy_reg * cfg.sin_angle;
            p_vc_reg   <= fy_reg * cfg.cos_angle;
            p_vs_reg   <= fx_reg * cfg.sin_angle;
            t_u_reg    <= t_u_next;
            t_v_reg    <= t_v_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            inside_reg <= inside_next;
            wr_en_reg  <= wr_en_next;
            addr_reg   <= addr_next;
        end
    end

    assign req = '{
        valid:           valid_reg[NUM_STG-1],
        operation:       carry_reg[NUM_STG-1].operation,
        in_bounds:       inside_reg,
        wr_en:           wr_en_reg,
        texel_value:     carry_reg[NUM_STG-1].texel_value,
        background_argb: carry_reg[NUM_STG-1].background_argb
    };
    assign addr = addr_reg;

endmodule

/* hw/rtl/rsac_blend.sv */
// Texel expansion and alpha blend: one register stage of channel products,
// then divide by 255 and selection. Depends on rsac_pkg.
module rsac_blend
    import rsac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  blend_req_t         req,
    input  logic [TEXEL_W-1:0] texel,
    output result_t            res
);

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [3:0]  NIB_CLEAR    = 4'h0;
    localparam logic [3:0]  NIB_FULL     = 4'hF;

    logic               valid_reg;
    logic               inside_reg;
    logic [TEXEL_W-1:0] texel_reg;
    logic [ARGB_W-1:0]  bg_reg;
    logic [15:0]        mix_reg  [3];
    logic [15:0]        mix_next [3];

    logic [7:0]  sa, inv_a, sc, dc;
    logic [15:0] quo;
    logic [7:0]  ch_out [3];
    logic [ARGB_W-1:0] expanded;

    always_comb
    begin
        sa    = {texel[15:12], texel[15:12]};
        inv_a = ALPHA_OPAQUE - sa;
        for (int ch = 0; ch < 3; ch++)
        begin
            sc = {texel[4*ch +: 4], texel[4*ch +: 4]};
            dc = req.background_argb[8*ch +: 8];
            mix_next[ch] = 16'(sc) * 16'(sa) + 16'(dc) * 16'(inv_a);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= req.in_bounds;
            texel_reg  <= texel;
            bg_reg     <= req.background_argb;
            for (int ch = 0; ch < 3; ch++)
            begin
                mix_reg[ch] <= mix_next[ch];
            end
        end
    end

    always_comb
    begin
        // x / 255 = (x + 1 + (x >> 8)) >> 8 for x up to 255 * 255
        for (int ch = 0; ch < 3; ch++)
        begin
            quo = mix_reg[ch] + 16'd1 + {8'd0, mix_reg[ch][15:8]};
            ch_out[ch] = quo[15:8];
        end
        expanded = {texel_reg[15:12], texel_reg[15:12], texel_reg[11:8], texel_reg[11:8],
                    texel_reg[7:4], texel_reg[7:4], texel_reg[3:0], texel_reg[3:0]};
        res.valid = valid_reg;
        priority if (!inside_reg || texel_reg[15:12] == NIB_CLEAR)
        begin
            res.pixel_argb = bg_reg;
            res.sprite_hit = 1'b0;
        end
        else if (texel_reg[15:12] == NIB_FULL)
        begin
            res.pixel_argb = expanded;
            res.sprite_hit = 1'b1;
        end
        else
        begin
            res.pixel_argb = {ALPHA_OPAQUE, ch_out[2], ch_out[1], ch_out[0]};
            res.sprite_hit = 1'b1;
        end
    end

endmodule
